### rtl/clt_pkg.sv
// Shared types and constants of the command line tokenizer.
`default_nettype none

package clt_pkg;

    // Widths and reset values
    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int POS_OUT_W = 16;
    localparam int LEN_W = 16;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

    // Result queue depth; an item may push two results at once
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_QUOTE     = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [2:0] ERR_SEPARATOR = 3'd4;

    // Parse modes
    typedef enum logic [9:0] {
        M_SKIP    = 10'b00_0000_0001,
        M_COMMENT = 10'b00_0000_0010,
        M_BARE    = 10'b00_0000_0100,
        M_TRAIL   = 10'b00_0000_1000,
        M_QUOTED  = 10'b00_0001_0000,
        M_ESC     = 10'b00_0010_0000,
        M_HEX1    = 10'b00_0100_0000,
        M_HEX2    = 10'b00_1000_0000,
        M_AFTERQ  = 10'b01_0000_0000,
        M_DRAIN   = 10'b10_0000_0000
    } mode_t;

    // Parser state apart from the positions
    typedef struct packed {
        mode_t             mode;
        logic              quote_dbl;
        logic [3:0]        hex_hi;
        logic [LEN_W-1:0]  tok_len;
    } state_t;

    // One result record
    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           token_byte;
        logic                 command_end;
        logic [2:0]           error_code;
        logic [POS_OUT_W-1:0] start_line;
        logic [POS_OUT_W-1:0] start_column;
        logic                 last;
    } rec_t;

    // Results of one item, in order
    typedef struct packed {
        logic [1:0] count;
        rec_t       r0;
        rec_t       r1;
    } step_out_t;

endpackage

`default_nettype wire

### rtl/clt_if.sv
// Handshake channels of the command line tokenizer: input bytes, results, configuration.
`default_nettype none

interface clt_item_if ();
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       stream_end;

    modport source (output valid, output byte_in, output stream_end, input ready);
    modport sink   (input valid, input byte_in, input stream_end, output ready);
endinterface

interface clt_result_if import clt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [7:0]           token_byte;
    logic                 command_end;
    logic [2:0]           error_code;
    logic [POS_OUT_W-1:0] start_line;
    logic [POS_OUT_W-1:0] start_column;
    logic                 last;

    modport source (output valid, output kind, output token_byte, output command_end,
                    output error_code, output start_line, output start_column,
                    output last, input ready);
    modport sink   (input valid, input kind, input token_byte, input command_end,
                    input error_code, input start_line, input start_column,
                    input last, output ready);
endinterface

interface clt_cfg_if import clt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/clt_step.sv
// Next-state and result logic for one input byte or end-of-stream mark.
`default_nettype none

module clt_step
    import clt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  state_t                   state,
    input  logic [POSITION_BITS-1:0] line,
    input  logic [POSITION_BITS-1:0] column,
    input  logic [POSITION_BITS-1:0] tok_line,
    input  logic [POSITION_BITS-1:0] tok_column,
    input  logic [LEN_W-1:0]         max_len,
    input  logic [7:0]               byte_in,
    input  logic                     stream_end,
    output state_t                   state_next,
    output logic [POSITION_BITS-1:0] line_next,
    output logic [POSITION_BITS-1:0] column_next,
    output logic [POSITION_BITS-1:0] tok_line_next,
    output logic [POSITION_BITS-1:0] tok_column_next,
    output step_out_t                res
);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BS    = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_X     = 8'h78;

    // Decode a hex digit: bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    logic             is_nl, is_semi, is_hash, is_dq, is_sq, is_bs, is_blank, is_quote;
    logic [4:0]       hex;
    logic             start;
    logic             end_v, end_cmd;
    logic             push_v, push_ok;
    logic [7:0]       push_b;
    logic             err_v;
    logic [2:0]       err_c;
    logic [LEN_W-1:0] len_base;
    rec_t             end_rec, second_rec;
    logic             second_v;

    assign is_nl    = (byte_in == CH_NL);
    assign is_semi  = (byte_in == CH_SEMI);
    assign is_hash  = (byte_in == CH_HASH);
    assign is_dq    = (byte_in == CH_DQ);
    assign is_sq    = (byte_in == CH_SQ);
    assign is_bs    = (byte_in == CH_BS);
    assign is_blank = is_nl || byte_in == CH_SP || byte_in == CH_TAB || byte_in == CH_VT
                      || byte_in == CH_FF || byte_in == CH_CR;
    assign is_quote = state.quote_dbl ? is_dq : is_sq;
    assign hex      = hex_digit(byte_in);

    // Mode update and the results it calls for
    always_comb
    begin
        state_next      = state;
        tok_line_next   = tok_line;
        tok_column_next = tok_column;
        start    = 1'b0;
        end_v    = 1'b0;
        end_cmd  = 1'b0;
        push_v   = 1'b0;
        push_b   = byte_in;
        err_v    = 1'b0;
        err_c    = ERR_NONE;
        len_base = state.tok_len;
        push_ok  = 1'b0;

        if (stream_end)
        begin
            case (state.mode)
                M_BARE, M_TRAIL, M_AFTERQ:
                begin
                    end_v   = 1'b1;
                    end_cmd = 1'b1;
                end
                M_QUOTED:
                begin
                    err_v = 1'b1;
                    err_c = ERR_QUOTE;
                end
                M_ESC, M_HEX1, M_HEX2:
                begin
                    err_v = 1'b1;
                    err_c = ERR_ESCAPE;
                end
                default: ;
            endcase
            state_next.mode = M_SKIP;
        end
        else
        begin
            case (state.mode)
                M_COMMENT, M_DRAIN:
                begin
                    if (is_nl) state_next.mode = M_SKIP;
                end
                M_BARE:
                begin
                    if (is_nl || is_semi)
                    begin
                        end_v = 1'b1;
                        end_cmd = 1'b1;
                        state_next.mode = M_SKIP;
                    end
                    else if (is_blank) state_next.mode = M_TRAIL;
                    else push_v = 1'b1;
                end
                M_TRAIL:
                begin
                    if (is_nl || is_semi)
                    begin
                        end_v = 1'b1;
                        end_cmd = 1'b1;
                        state_next.mode = M_SKIP;
                    end
                    else if (is_hash)
                    begin
                        end_v = 1'b1;
                        end_cmd = 1'b1;
                        state_next.mode = M_COMMENT;
                    end
                    else if (!is_blank)
                    begin
                        end_v = 1'b1;
                        start = 1'b1;
                    end
                end
                M_AFTERQ:
                begin
                    if (is_nl || is_semi)
                    begin
                        end_v = 1'b1;
                        end_cmd = 1'b1;
                        state_next.mode = M_SKIP;
                    end
                    else if (is_blank) state_next.mode = M_TRAIL;
                    else
                    begin
                        err_v = 1'b1;
                        err_c = ERR_SEPARATOR;
                        state_next.mode = M_DRAIN;
                    end
                end
                M_QUOTED:
                begin
                    if (is_nl)
                    begin
                        err_v = 1'b1;
                        err_c = ERR_QUOTE;
                        state_next.mode = M_SKIP;
                    end
                    else if (is_quote) state_next.mode = M_AFTERQ;
                    else if (is_bs) state_next.mode = M_ESC;
                    else push_v = 1'b1;
                end
                M_ESC:
                begin
                    if (is_dq || is_sq || is_bs)
                    begin
                        state_next.mode = M_QUOTED;
                        push_v = 1'b1;
                    end
                    else if (byte_in == CH_N)
                    begin
                        state_next.mode = M_QUOTED;
                        push_v = 1'b1;
                        push_b = CH_NL;
                    end
                    else if (byte_in == CH_X) state_next.mode = M_HEX1;
                    else
                    begin
                        err_v = 1'b1;
                        err_c = ERR_ESCAPE;
                        state_next.mode = M_DRAIN;
                    end
                end
                M_HEX1:
                begin
                    if (!hex[4])
                    begin
                        err_v = 1'b1;
                        err_c = ERR_ESCAPE;
                        state_next.mode = M_DRAIN;
                    end
                    else
                    begin
                        state_next.hex_hi = hex[3:0];
                        state_next.mode = M_HEX2;
                    end
                end
                M_HEX2:
                begin
                    if (!hex[4])
                    begin
                        err_v = 1'b1;
                        err_c = ERR_ESCAPE;
                        state_next.mode = M_DRAIN;
                    end
                    else
                    begin
                        state_next.mode = M_QUOTED;
                        push_v = 1'b1;
                        push_b = {state.hex_hi, hex[3:0]};
                    end
                end
                default:
                begin
                    if (is_blank || is_semi) state_next.mode = M_SKIP;
                    else if (is_hash) state_next.mode = M_COMMENT;
                    else start = 1'b1;
                end
            endcase

            // Open a new token at this byte
            if (start)
            begin
                tok_line_next   = line;
                tok_column_next = column;
                len_base        = '0;
                if (is_dq || is_sq)
                begin
                    state_next.quote_dbl = is_dq;
                    state_next.mode = M_QUOTED;
                end
                else
                begin
                    state_next.mode = M_BARE;
                    push_v = 1'b1;
                end
            end

            // Append a byte, or fail when the token is full
            state_next.tok_len = len_base;
            if (push_v)
            begin
                if (len_base >= max_len)
                begin
                    err_v = 1'b1;
                    err_c = ERR_TOO_LONG;
                    state_next.mode = M_DRAIN;
                end
                else
                begin
                    push_ok = 1'b1;
                    state_next.tok_len = len_base + 1'b1;
                end
            end
        end
    end

    // Advance the text position, saturating; restart it at end of stream
    always_comb
    begin
        line_next   = line;
        column_next = column;
        if (stream_end)
        begin
            line_next   = POSITION_BITS'(1);
            column_next = POSITION_BITS'(1);
        end
        else if (is_nl)
        begin
            if (!(&line)) line_next = line + 1'b1;
            column_next = POSITION_BITS'(1);
        end
        else if (!(&column))
        begin
            column_next = column + 1'b1;
        end
    end

    // Assemble the results: a token end always comes first
    always_comb
    begin
        end_rec              = '0;
        end_rec.kind         = KIND_END;
        end_rec.command_end  = end_cmd;
        end_rec.error_code   = ERR_NONE;
        end_rec.start_line   = POS_OUT_W'(tok_line);
        end_rec.start_column = POS_OUT_W'(tok_column);

        second_rec              = '0;
        second_rec.kind         = push_ok ? KIND_BYTE : KIND_ERR;
        second_rec.token_byte   = push_ok ? push_b : 8'd0;
        second_rec.error_code   = push_ok ? ERR_NONE : err_c;
        second_rec.start_line   = POS_OUT_W'(tok_line_next);
        second_rec.start_column = POS_OUT_W'(tok_column_next);
        second_rec.last         = 1'b1;

        second_v = push_ok || err_v;

        res.count = {1'b0, end_v} + {1'b0, second_v};
        res.r1    = second_rec;
        if (end_v)
        begin
            res.r0      = end_rec;
            res.r0.last = !second_v;
        end
        else
        begin
            res.r0 = second_rec;
        end
    end

endmodule

`default_nettype wire

### rtl/clt_res_fifo.sv
// Result queue: takes up to two records a cycle, hands out one per transfer.
`default_nettype none

module clt_res_fifo
    import clt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  step_out_t          push_data,
    output logic               room2,
    clt_result_if.source       result
);

    rec_t                 mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_reg, rd_reg;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_CNT_W-1:0] n_in;
    logic                 pop;
    rec_t                 head;

    assign n_in  = push ? RES_CNT_W'(push_data.count) : '0;
    assign pop   = result.valid && result.ready;
    assign room2 = (cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign cnt_next = cnt_reg + n_in - RES_CNT_W'(pop);

    // Hold pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + RES_PTR_W'(n_in);
            rd_reg  <= rd_reg + RES_PTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

    // Write the new records in order
    always_ff @(posedge clk)
    begin
        if (push && push_data.count != 2'd0)
        begin
            mem[wr_reg] <= push_data.r0;
            if (push_data.count == 2'd2)
                mem[wr_reg + RES_PTR_W'(1)] <= push_data.r1;
        end
    end

    assign head = mem[rd_reg];

    assign result.valid        = (cnt_reg != '0);
    assign result.kind         = head.kind;
    assign result.token_byte   = head.token_byte;
    assign result.command_end  = head.command_end;
    assign result.error_code   = head.error_code;
    assign result.start_line   = head.start_line;
    assign result.start_column = head.start_column;
    assign result.last         = head.last;

endmodule

`default_nettype wire

### rtl/command_line_tokenizer.sv
// Top level of the command line tokenizer: input register, parser state, result queue.
`default_nettype none

// Streaming shell-style tokenizer. One byte (or an end-of-stream mark) is taken per
// item and the block accepts a new item every cycle while the result queue has room
// for two records. Each item is held in an input register while the parser state and
// its results are worked out, and the results go into a four-entry result queue; the
// first result of an item is offered from that queue after the input register. Most
// items give at most one result; a byte that closes one token and opens another gives
// two, which leave the queue over two output transfers, so the sustained rate is one
// item per cycle as long as results are taken as fast as they are made. The token
// length limit is written on the configuration channel (reset 1024) and takes effect
// for the next byte; write it only while no result is outstanding.
module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    clt_item_if.sink      item,
    clt_result_if.source  result,
    clt_cfg_if.sink       cfg
);

    logic                     s1_valid_reg;
    logic [7:0]               s1_byte_reg;
    logic                     s1_eos_reg;
    logic                     room2;
    logic                     fire;

    state_t                   state_reg, state_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] tline_reg, tline_next;
    logic [POSITION_BITS-1:0] tcol_reg, tcol_next;
    logic [LEN_W-1:0]         max_len_reg;
    step_out_t                step_res;

    // Process the held item once the queue can take two records
    assign fire       = s1_valid_reg && room2;
    assign item.ready = !s1_valid_reg || room2;
    assign cfg.ready  = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_byte_reg <= item.byte_in;
            s1_eos_reg  <= item.stream_end;
        end
    end

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg.valid && cfg.ready)
            max_len_reg <= cfg.data;
    end

    clt_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .state           (state_reg),
        .line            (line_reg),
        .column          (col_reg),
        .tok_line        (tline_reg),
        .tok_column      (tcol_reg),
        .max_len         (max_len_reg),
        .byte_in         (s1_byte_reg),
        .stream_end      (s1_eos_reg),
        .state_next      (state_next),
        .line_next       (line_next),
        .column_next     (col_next),
        .tok_line_next   (tline_next),
        .tok_column_next (tcol_next),
        .res             (step_res)
    );

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode      <= M_SKIP;
            state_reg.quote_dbl <= 1'b0;
            state_reg.hex_hi    <= '0;
            state_reg.tok_len   <= '0;
            line_reg            <= POSITION_BITS'(1);
            col_reg             <= POSITION_BITS'(1);
            tline_reg           <= '0;
            tcol_reg            <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

    clt_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (step_res),
        .room2     (room2),
        .result    (result)
    );

    // An end of stream restarts the position at line 1, column 1
    a_eos_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_eos_reg |=> line_reg == POSITION_BITS'(1) && col_reg == POSITION_BITS'(1))
        else $error("position not restarted after end of stream");

    // An end of stream outside a token gives no result
    a_eos_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_eos_reg && (state_reg.mode == M_SKIP || state_reg.mode == M_COMMENT
            || state_reg.mode == M_DRAIN) |-> step_res.count == 2'd0)
        else $error("result produced by end of stream outside a token");

    // Two results from one byte always open with a token end
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_res.count == 2'd2 |-> step_res.r0.kind == KIND_END && !step_res.r0.last)
        else $error("two results without a leading token end");

endmodule

`default_nettype wire

### test/token_stream_checker.sv
// Checker for the command line tokenizer: predicts the results of each byte and compares them.
module token_stream_checker
    import clt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    clt_item_if   item,
    clt_result_if result,
    clt_cfg_if    cfg,
    output int    error_count,
    output int    results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] VT_CH = 8'h0B;
    localparam logic [7:0] FF_CH = 8'h0C;
    localparam logic [15:0] POS_TOP = 16'hFFFF;

    // Shadow copy of the parser state and the length limit
    mode_t       scan_mode;
    logic        dbl_quote;
    logic [3:0]  hex_hi;
    logic [15:0] tok_len;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] len_limit;

    rec_t predicted_results[$];
    rec_t step_recs[$];
    rec_t want;
    int   mismatches;

    function automatic logic is_space(logic [7:0] c);
        return c == " " || c == "\t" || c == "\n" || c == VT_CH || c == FF_CH || c == "\r";
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return 10 + int'(c - "a");
        if (c >= "A" && c <= "F")
            return 10 + int'(c - "A");
        return -1;
    endfunction

    // Record one result of the current byte, at most two per byte
    function automatic void note_result(logic [1:0] k, logic [7:0] b, logic cmd, logic [2:0] err);
        rec_t r;
        if (step_recs.size() >= 2)
            return;
        r.kind         = k;
        r.token_byte   = b;
        r.command_end  = cmd;
        r.error_code   = err;
        r.start_line   = tok_line;
        r.start_column = tok_col;
        r.last         = 1'b0;
        step_recs.push_back(r);
    endfunction

    function automatic void raise_error(logic [2:0] code, mode_t next);
        note_result(KIND_ERR, 8'h00, 1'b0, code);
        scan_mode = next;
    endfunction

    // Emit a token byte, or fail once the limit is reached
    function automatic void take_token_byte(logic [7:0] b);
        if (tok_len >= len_limit)
        begin
            raise_error(ERR_TOO_LONG, M_DRAIN);
            return;
        end
        tok_len++;
        note_result(KIND_BYTE, b, 1'b0, ERR_NONE);
    endfunction

    // Between tokens: skip separators or open a new token
    function automatic void begin_or_skip(logic [7:0] c);
        if (is_space(c) || c == ";")
            scan_mode = M_SKIP;
        else if (c == "#")
            scan_mode = M_COMMENT;
        else
        begin
            tok_line = line_no;
            tok_col  = col_no;
            tok_len  = '0;
            if (c == "\"" || c == "'")
            begin
                dbl_quote = (c == "\"");
                scan_mode = M_QUOTED;
            end
            else
            begin
                scan_mode = M_BARE;
                take_token_byte(c);
            end
        end
    endfunction

    function automatic void close_stream();
        case (scan_mode)
            M_BARE, M_TRAIL, M_AFTERQ: note_result(KIND_END, 8'h00, 1'b1, ERR_NONE);
            M_QUOTED:                  note_result(KIND_ERR, 8'h00, 1'b0, ERR_QUOTE);
            M_ESC, M_HEX1, M_HEX2:     note_result(KIND_ERR, 8'h00, 1'b0, ERR_ESCAPE);
            default: ;
        endcase
        scan_mode = M_SKIP;
        line_no   = 16'd1;
        col_no    = 16'd1;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        int h;
        case (scan_mode)
            M_COMMENT, M_DRAIN:
            begin
                if (c == "\n")
                    scan_mode = M_SKIP;
            end
            M_BARE:
            begin
                if (c == "\n" || c == ";")
                begin
                    note_result(KIND_END, 8'h00, 1'b1, ERR_NONE);
                    scan_mode = M_SKIP;
                end
                else if (is_space(c))
                    scan_mode = M_TRAIL;
                else
                    take_token_byte(c);
            end
            M_TRAIL:
            begin
                if (c == "\n" || c == ";")
                begin
                    note_result(KIND_END, 8'h00, 1'b1, ERR_NONE);
                    scan_mode = M_SKIP;
                end
                else if (c == "#")
                begin
                    note_result(KIND_END, 8'h00, 1'b1, ERR_NONE);
                    scan_mode = M_COMMENT;
                end
                else if (!is_space(c))
                begin
                    note_result(KIND_END, 8'h00, 1'b0, ERR_NONE);
                    begin_or_skip(c);
                end
            end
            M_AFTERQ:
            begin
                if (c == "\n" || c == ";")
                begin
                    note_result(KIND_END, 8'h00, 1'b1, ERR_NONE);
                    scan_mode = M_SKIP;
                end
                else if (is_space(c))
                    scan_mode = M_TRAIL;
                else
                    raise_error(ERR_SEPARATOR, M_DRAIN);
            end
            M_QUOTED:
            begin
                if (c == "\n")
                    raise_error(ERR_QUOTE, M_SKIP);
                else if (c == (dbl_quote ? 8'("\"") : 8'("'")))
                    scan_mode = M_AFTERQ;
                else if (c == "\\")
                    scan_mode = M_ESC;
                else
                    take_token_byte(c);
            end
            M_ESC:
            begin
                if (c == "\"" || c == "'" || c == "\\")
                begin
                    scan_mode = M_QUOTED;
                    take_token_byte(c);
                end
                else if (c == "n")
                begin
                    scan_mode = M_QUOTED;
                    take_token_byte(8'h0A);
                end
                else if (c == "x")
                    scan_mode = M_HEX1;
                else
                    raise_error(ERR_ESCAPE, M_DRAIN);
            end
            M_HEX1:
            begin
                h = hex_digit(c);
                if (h < 0)
                    raise_error(ERR_ESCAPE, M_DRAIN);
                else
                begin
                    hex_hi    = 4'(h);
                    scan_mode = M_HEX2;
                end
            end
            M_HEX2:
            begin
                h = hex_digit(c);
                if (h < 0)
                    raise_error(ERR_ESCAPE, M_DRAIN);
                else
                begin
                    scan_mode = M_QUOTED;
                    take_token_byte({hex_hi, 4'(h)});
                end
            end
            default: begin_or_skip(c);
        endcase
        // Advance the position, saturating
        if (c == "\n")
        begin
            if (line_no < POS_TOP)
                line_no++;
            col_no = 16'd1;
        end
        else if (col_no < POS_TOP)
            col_no++;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Track configuration, predict on each input transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode  = M_SKIP;
            dbl_quote  = 1'b0;
            hex_hi     = '0;
            tok_len    = '0;
            line_no    = 16'd1;
            col_no     = 16'd1;
            tok_line   = '0;
            tok_col    = '0;
            len_limit  = MAX_LEN_RESET;
            mismatches = 0;
            predicted_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                len_limit = cfg.data;

            if (item.valid && item.ready)
            begin
                step_recs.delete();
                if (item.stream_end)
                    close_stream();
                else
                    scan_byte(item.byte_in);
                if (step_recs.size() > 0)
                    step_recs[step_recs.size() - 1].last = 1'b1;
                foreach (step_recs[i])
                    predicted_results.push_back(step_recs[i]);
            end

            if (result.valid && result.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d byte %0h", result.kind, result.token_byte);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("kind", want.kind, result.kind);
                    check_field("token_byte", want.token_byte, result.token_byte);
                    check_field("command_end", want.command_end, result.command_end);
                    check_field("error_code", want.error_code, result.error_code);
                    check_field("start_line", want.start_line, result.start_line);
                    check_field("start_column", want.start_column, result.start_column);
                    check_field("last", want.last, result.last);
                end
            end
        end
        error_count <= mismatches;
        results_due <= predicted_results.size();
    end

endmodule

### test/command_line_tokenizer_tb.sv
// Top of the command line tokenizer testbench: clock, reset, stimulus and verdict.
module command_line_tokenizer_tb
    import clt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] VT_CH = 8'h0B;
    localparam logic [7:0] FF_CH = 8'h0C;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 205;

    logic clk;
    logic rst_n;
    logic item_took = 1'b0;
    logic cfg_took = 1'b0;
    int   error_count;
    int   results_due;
    int   items_sent = 0;
    int   burst_left = 0;

    // Pending text: bit 8 marks end of stream
    logic [8:0]  text_q[$];
    logic [15:0] phase_limit [PHASE_COUNT];

    clt_item_if   item_ch ();
    clt_result_if result_ch ();
    clt_cfg_if    cfg_ch ();

    command_line_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    token_stream_checker token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .error_count (error_count),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Note the handshakes of each edge for the falling-edge drivers
    always @(posedge clk)
    begin
        item_took <= item_ch.valid && item_ch.ready;
        cfg_took  <= cfg_ch.valid && cfg_ch.ready;
    end

    // Stall the result channel on a rotating mask that changes now and then
    initial
    begin
        logic [7:0] accept_mask;
        int hold;
        result_ch.ready = 1'b0;
        accept_mask = 8'hFF;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                hold = $urandom_range(20, 80);
                accept_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            end
            hold--;
            result_ch.ready <= accept_mask[0];
            accept_mask = {accept_mask[0], accept_mask[7:1]};
        end
    end

    function automatic logic is_space(logic [7:0] c);
        return c == " " || c == "\t" || c == "\n" || c == VT_CH || c == FF_CH || c == "\r";
    endfunction

    function automatic void push_char(logic [7:0] c);
        text_q.push_back({1'b0, c});
    endfunction

    function automatic void push_stream_end();
        text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic void add_blanks(int min_n);
        logic [7:0] pick [5] = '{" ", "\t", VT_CH, FF_CH, "\r"};
        repeat ($urandom_range(min_n, 3))
            push_char(pick[$urandom_range(0, 4)]);
    endfunction

    function automatic logic [7:0] plain_char(logic first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_space(c) || c == ";" || (first && (c == "#" || c == "\"" || c == "'")));
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'("0" + v);
        if (v < 16)
            return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    function automatic void add_bare();
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        push_char(plain_char(1'b1));
        repeat (len - 1)
            push_char(plain_char(1'b0));
    endfunction

    function automatic void add_escape();
        push_char("\\");
        case ($urandom_range(0, 4))
            0: push_char("\"");
            1: push_char("'");
            2: push_char("\\");
            3: push_char("n");
            default:
            begin
                push_char("x");
                push_char(hex_char());
                push_char(hex_char());
            end
        endcase
    endfunction

    // Quoted token; a broken one ends in one of the quoting errors
    function automatic void add_quoted(logic broken);
        logic [7:0] q;
        logic [7:0] c;
        q = $urandom_range(0, 1) ? 8'("\"") : 8'("'");
        push_char(q);
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 2) == 0)
                add_escape();
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == "\n" || c == q || c == "\\");
                push_char(c);
            end
        end
        if (!broken)
        begin
            push_char(q);
            return;
        end
        case ($urandom_range(0, 4))
            0: push_char("\n");
            1:
            begin
                case ($urandom_range(0, 3))
                    1: push_char("\\");
                    2: begin push_char("\\"); push_char("x"); end
                    3: begin push_char("\\"); push_char("x"); push_char(hex_char()); end
                    default: ;
                endcase
                push_stream_end();
            end
            2:
            begin
                push_char("\\");
                do
                    c = 8'($urandom_range(0, 255));
                while (c == "\"" || c == "'" || c == "\\" || c == "n" || c == "x");
                push_char(c);
            end
            3:
            begin
                push_char("\\");
                push_char("x");
                if ($urandom_range(0, 1))
                    push_char(hex_char());
                do
                    c = 8'($urandom_range(0, 255));
                while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
                push_char(c);
            end
            default:
            begin
                push_char(q);
                push_char(plain_char(1'b0));
            end
        endcase
    endfunction

    // One command: tokens, blanks and usually a terminator; now and then raw noise instead
    function automatic void add_command();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                push_char(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            add_blanks(1);
        for (int i = 0; i < $urandom_range(1, 3); i++)
        begin
            if (i > 0)
                add_blanks(1);
            if ($urandom_range(0, 2) == 0)
                add_quoted($urandom_range(0, 6) == 0);
            else
                add_bare();
        end
        if ($urandom_range(0, 1))
            add_blanks(1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: push_char("\n");
            4, 5:       push_char(";");
            6, 7:
            begin
                push_char("#");
                repeat ($urandom_range(0, 5))
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == "\n");
                    push_char(c);
                end
                push_char("\n");
            end
            8:       push_stream_end();
            default: ;
        endcase
    endfunction

    // Offer one item, in bursts with random gaps
    task automatic send_item(input logic [8:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
        end
        burst_left--;
        item_ch.valid      <= 1'b1;
        item_ch.byte_in    <= v[7:0];
        item_ch.stream_end <= v[8];
        do
            @(negedge clk);
        while (!item_took);
        items_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0)
            send_item(text_q.pop_front());
    endtask

    // Drop valid and wait until every result is in and the pipeline is empty
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(negedge clk);
        while (!cfg_took);
        cfg_ch.valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        string opening_text;
        int phase_start;
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.byte_in    = '0;
        item_ch.stream_end = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        phase_limit = '{MAX_LEN_RESET, 16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd2, 16'd1024};
        phase_limit[5] = 16'($urandom_range(2, 8));
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: byte extremes, trailing comment, hex and newline escapes,
        // missing separator, bad escape, and a token closed by end of stream
        push_char(8'h00);
        push_char(8'hFF);
        opening_text = " #\n\"\\xaF\\n\"b\n'\\q\nk";
        for (int i = 0; i < opening_text.len(); i++)
            push_char(opening_text[i]);
        push_stream_end();
        send_text();

        // Random commands under a series of length limits
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                write_limit(phase_limit[p]);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                add_command();
                send_text();
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (error_count == 0 && results_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hold a hard limit on the run
    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/clt_pkg.sv
rtl/clt_if.sv
rtl/clt_step.sv
rtl/clt_res_fifo.sv
rtl/command_line_tokenizer.sv
test/token_stream_checker.sv
test/command_line_tokenizer_tb.sv
